>>> rtl/hequ_pkg.sv
// Shared types, widths and saturating helpers for the histogram equalizer.
// No dependencies.
package hequ_pkg;

  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned BIN_COUNT  = 256;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ADDR_W     = $clog2(BIN_COUNT);
  localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SUM_W      = CNT_W + 2;
  localparam int unsigned DIV_W      = CNT_W + 9;
  localparam int unsigned QUO_W      = 9;
  localparam int unsigned RECIP_SH   = SUM_W + 2;
  localparam logic [RECIP_SH-1:0] RECIP3 = RECIP_SH'((2 ** RECIP_SH + 2) / 3);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_MAP   = 1'b1;

  localparam logic [1:0] CH_RED = 2'd0;
  localparam logic [1:0] CH_GRN = 2'd1;
  localparam logic [1:0] CH_BLU = 2'd2;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v < MAX_CNT) ? v + CNT_W'(1) : MAX_CNT;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = (s > {1'b0, MAX_CNT}) ? MAX_CNT : s[CNT_W-1:0];
  endfunction

endpackage

>>> rtl/hequ_front.sv
// Front end: accepts pixel commands and queues them for the back end.
// Depends on hequ_pkg.
module hequ_front import hequ_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  item_t  in_item,
  output qhead_t head,
  input  logic   pop
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  item_t            q_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;
  logic             push;
  logic             do_pop;

  assign busy   = (cnt_r == (PTR_W+1)'(DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

>>> rtl/hequ_back.sv
// Back end: histogram stores, cumulative build, clear sweep and pixel mapping.
// Depends on hequ_pkg.
module hequ_back import hequ_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  qhead_t           head,
  output logic             pop,
  input  logic             mode,
  output logic             res_valid,
  output logic [PIX_W-1:0] res_red,
  output logic [PIX_W-1:0] res_green,
  output logic [PIX_W-1:0] res_blue
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_CNT_RD  = 4'd2;
  localparam logic [3:0] S_CNT_WR  = 4'd3;
  localparam logic [3:0] S_CUM_RD  = 4'd4;
  localparam logic [3:0] S_CUM_DIV = 4'd5;
  localparam logic [3:0] S_CUM_WR  = 4'd6;
  localparam logic [3:0] S_MAP_RD  = 4'd7;
  localparam logic [3:0] S_MAP_MUL = 4'd8;
  localparam logic [3:0] S_MAP_CHK = 4'd9;
  localparam logic [3:0] S_MAP_DIV = 4'd10;
  localparam logic [3:0] S_INIT    = 4'd11;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(BIN_COUNT - 1);
  localparam logic [3:0]        TOP_BIT  = 4'(QUO_W - 1);

  logic [CNT_W-1:0] mem_red [BIN_COUNT];
  logic [CNT_W-1:0] mem_grn [BIN_COUNT];
  logic [CNT_W-1:0] mem_blu [BIN_COUNT];
  logic [CNT_W-1:0] mem_avg [BIN_COUNT];

  logic [3:0]        state_r, state_nxt;
  item_t             item_r;
  logic [ADDR_W-1:0] idx_r;
  logic [1:0]        ch_r;
  logic              map_pass_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  acc_red_r, acc_grn_r, acc_blu_r, acc_avg_r;
  logic [CNT_W-1:0]  rd_red_r, rd_grn_r, rd_blu_r, rd_avg_r;
  logic [CNT_W-1:0]  avg3_r;
  logic [DIV_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [3:0]        k_r;
  logic [PIX_W-1:0]  res_red_r, res_grn_r, res_blu_r;
  logic              res_valid_r;

  logic [ADDR_W-1:0] a_red, a_grn, a_blu, a_avg;
  logic              we_rgb, we_avg;
  logic [CNT_W-1:0]  wd_red, wd_grn, wd_blu, wd_avg;
  logic [PIX_W-1:0]  ch_val;
  logic [CNT_W-1:0]  cdf;
  logic [SUM_W-1:0]  sum3;
  logic [SUM_W+RECIP_SH-1:0] prod3;
  logic [DIV_W-1:0]  dsh;
  logic [DIV_W-1:0]  rem_nxt;
  logic [QUO_W-1:0]  quo_nxt;
  logic [PIX_W-1:0]  map_res;
  logic              map_done;
  logic [PIX_W-1:0]  chk_res;

  assign pop = (state_r == S_IDLE) && head.valid;

  always_comb begin
    case (ch_r)
      CH_RED:  ch_val = item_r.red;
      CH_GRN:  ch_val = item_r.green;
      default: ch_val = item_r.blue;
    endcase
  end

  always_comb begin
    if (mode) begin
      cdf = rd_avg_r;
    end else begin
      case (ch_r)
        CH_RED:  cdf = rd_red_r;
        CH_GRN:  cdf = rd_grn_r;
        default: cdf = rd_blu_r;
      endcase
    end
  end

  always_comb begin
    a_red = item_r.red;
    a_grn = item_r.green;
    a_blu = item_r.blue;
    a_avg = ch_val;
    if (state_r inside {S_INIT, S_CLR, S_CUM_RD, S_CUM_DIV, S_CUM_WR}) begin
      a_red = idx_r;
      a_grn = idx_r;
      a_blu = idx_r;
      a_avg = idx_r;
    end
  end

  assign sum3  = SUM_W'(rd_red_r) + SUM_W'(rd_grn_r) + SUM_W'(rd_blu_r);
  assign prod3 = sum3 * RECIP3;

  always_comb begin
    we_rgb = 1'b0;
    we_avg = 1'b0;
    wd_red = '0;
    wd_grn = '0;
    wd_blu = '0;
    wd_avg = '0;
    case (state_r)
      S_INIT, S_CLR: begin
        we_rgb = 1'b1;
        we_avg = 1'b1;
      end
      S_CNT_WR: begin
        we_rgb = 1'b1;
        wd_red = sat_inc(rd_red_r);
        wd_grn = sat_inc(rd_grn_r);
        wd_blu = sat_inc(rd_blu_r);
      end
      S_CUM_WR: begin
        we_rgb = 1'b1;
        we_avg = 1'b1;
        wd_red = sat_add(rd_red_r, acc_red_r);
        wd_grn = sat_add(rd_grn_r, acc_grn_r);
        wd_blu = sat_add(rd_blu_r, acc_blu_r);
        wd_avg = sat_add(avg3_r, acc_avg_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_rgb) begin
      mem_red[a_red] <= wd_red;
      mem_grn[a_grn] <= wd_grn;
      mem_blu[a_blu] <= wd_blu;
    end
    if (we_avg) begin
      mem_avg[a_avg] <= wd_avg;
    end
    rd_red_r <= mem_red[a_red];
    rd_grn_r <= mem_grn[a_grn];
    rd_blu_r <= mem_blu[a_blu];
    rd_avg_r <= mem_avg[a_avg];
  end

  always_comb begin
    dsh     = DIV_W'(total_r) << k_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (rem_r >= dsh) begin
      rem_nxt = rem_r - dsh;
      quo_nxt[k_r] = 1'b1;
    end
    map_res  = (quo_nxt > QUO_W'(PIX_MAX)) ? PIX_MAX : quo_nxt[PIX_W-1:0];
    map_done = (k_r == 4'd0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          if (head.item.func == FUNC_COUNT) begin
            state_nxt = map_pass_r ? S_CLR : S_CNT_RD;
          end else begin
            state_nxt = map_pass_r ? S_MAP_RD : S_CUM_RD;
          end
        end
      end
      S_INIT:    state_nxt = (idx_r == LAST_IDX) ? S_IDLE : S_INIT;
      S_CLR:     state_nxt = (idx_r == LAST_IDX) ? S_CNT_RD : S_CLR;
      S_CNT_RD:  state_nxt = S_CNT_WR;
      S_CNT_WR:  state_nxt = S_IDLE;
      S_CUM_RD:  state_nxt = S_CUM_DIV;
      S_CUM_DIV: state_nxt = S_CUM_WR;
      S_CUM_WR:  state_nxt = (idx_r == LAST_IDX) ? S_MAP_RD : S_CUM_RD;
      S_MAP_RD:  state_nxt = S_MAP_MUL;
      S_MAP_MUL: state_nxt = S_MAP_CHK;
      S_MAP_CHK: begin
        if (total_r == '0 || rem_r >= (DIV_W'(total_r) << QUO_W)) begin
          state_nxt = (ch_r == CH_BLU) ? S_IDLE : S_MAP_RD;
        end else begin
          state_nxt = S_MAP_DIV;
        end
      end
      S_MAP_DIV: begin
        if (map_done) begin
          state_nxt = (ch_r == CH_BLU) ? S_IDLE : S_MAP_RD;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  assign chk_res = (total_r == '0) ? '0 : PIX_MAX;

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head.item;
    end
    if (state_r == S_CUM_DIV) begin
      avg3_r <= CNT_W'(prod3 >> RECIP_SH);
    end
    if (state_r == S_MAP_MUL) begin
      rem_r <= DIV_W'(cdf) * DIV_W'(PIX_MAX);
      quo_r <= '0;
      k_r   <= TOP_BIT;
    end else if (state_r == S_MAP_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      k_r   <= k_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      ch_r        <= CH_RED;
      map_pass_r  <= 1'b0;
      total_r     <= '0;
      acc_red_r   <= '0;
      acc_grn_r   <= '0;
      acc_blu_r   <= '0;
      acc_avg_r   <= '0;
      res_red_r   <= '0;
      res_grn_r   <= '0;
      res_blu_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          idx_r     <= '0;
          ch_r      <= CH_RED;
          acc_red_r <= '0;
          acc_grn_r <= '0;
          acc_blu_r <= '0;
          acc_avg_r <= '0;
        end
        S_INIT: idx_r <= idx_r + ADDR_W'(1);
        S_CLR: begin
          idx_r <= idx_r + ADDR_W'(1);
          if (idx_r == LAST_IDX) begin
            total_r    <= '0;
            map_pass_r <= 1'b0;
          end
        end
        S_CNT_WR: total_r <= sat_inc(total_r);
        S_CUM_WR: begin
          acc_red_r <= wd_red;
          acc_grn_r <= wd_grn;
          acc_blu_r <= wd_blu;
          acc_avg_r <= wd_avg;
          idx_r     <= idx_r + ADDR_W'(1);
          if (idx_r == LAST_IDX) begin
            map_pass_r <= 1'b1;
          end
        end
        S_MAP_CHK: begin
          if (state_nxt != S_MAP_DIV) begin
            case (ch_r)
              CH_RED:  res_red_r <= chk_res;
              CH_GRN:  res_grn_r <= chk_res;
              default: res_blu_r <= chk_res;
            endcase
            ch_r <= ch_r + 2'd1;
            if (ch_r == CH_BLU) begin
              res_valid_r <= 1'b1;
            end
          end
        end
        S_MAP_DIV: begin
          if (map_done) begin
            case (ch_r)
              CH_RED:  res_red_r <= map_res;
              CH_GRN:  res_grn_r <= map_res;
              default: res_blu_r <= map_res;
            endcase
            ch_r <= ch_r + 2'd1;
            if (ch_r == CH_BLU) begin
              res_valid_r <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res_red   = res_red_r;
  assign res_green = res_grn_r;
  assign res_blue  = res_blu_r;

endmodule

>>> rtl/histogram_equalizer_rgb_unit.sv
// Top level of the RGB histogram equalizer: command queue plus store/map engine.
// Depends on hequ_pkg, hequ_front and hequ_back.
//
//   channel   ports                                  transfer when
//   input     start, busy, in_func, in_*_in          start && !busy
//   result    out_valid, out_*_out                   out_valid (one cycle)
//   config    cfg_we, cfg_average_mode               cfg_we
//
// A count item reads, then writes, the three channel stores; the first count after
// a map pass adds a clear sweep over all bins. The first map item after counting
// adds a cumulative build (read, divide, write per bin). A map item then runs the
// one-bit-per-cycle divider per channel, unless the total is zero or it saturates.
// A 4-entry queue takes items while the engine works; busy is high when it is full.
// Reset is synchronous; after reset a sweep over all 256 bins zeroes the stores before
// the engine takes its first item from the queue. Results cannot be stalled.
module histogram_equalizer_rgb_unit import hequ_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_func,
  input  logic [PIX_W-1:0] in_red_in,
  input  logic [PIX_W-1:0] in_green_in,
  input  logic [PIX_W-1:0] in_blue_in,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_red_out,
  output logic [PIX_W-1:0] out_green_out,
  output logic [PIX_W-1:0] out_blue_out,
  input  logic             cfg_we,
  input  logic             cfg_average_mode
);

  logic   mode_r;
  item_t  in_item;
  qhead_t head;
  logic   pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_average_mode;
    end
  end

  assign in_item.func  = in_func;
  assign in_item.red   = in_red_in;
  assign in_item.green = in_green_in;
  assign in_item.blue  = in_blue_in;

  hequ_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  hequ_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .mode      (mode_r),
    .res_valid (out_valid),
    .res_red   (out_red_out),
    .res_green (out_green_out),
    .res_blue  (out_blue_out)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for histogram_equalizer_rgb_unit: count and map passes checked against
// a cycle-free predictor held in a small scoreboard class. Depends on hequ_pkg.
module testbench;
  import hequ_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  class equalizer_scoreboard;
    int unsigned red_cdf[BIN_COUNT];
    int unsigned green_cdf[BIN_COUNT];
    int unsigned blue_cdf[BIN_COUNT];
    int unsigned avg_cdf[BIN_COUNT];
    int unsigned pixel_total;
    bit mapping;
    bit avg_mode;
    rgb_t mapped_pixels[$];
    int mismatches;

    function void clear_bins();
      for (int i = 0; i < BIN_COUNT; i++) begin
        red_cdf[i] = 0;
        green_cdf[i] = 0;
        blue_cdf[i] = 0;
        avg_cdf[i] = 0;
      end
      pixel_total = 0;
    endfunction

    function int unsigned bump(int unsigned v);
      return (v < MAX_PIXELS) ? v + 1 : MAX_PIXELS;
    endfunction

    function int unsigned sum_sat(int unsigned a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      return (s > MAX_PIXELS) ? MAX_PIXELS : int'(s);
    endfunction

    function void accumulate();
      for (int i = 0; i < BIN_COUNT; i++)
        avg_cdf[i] = int'((longint'(red_cdf[i]) + green_cdf[i] + blue_cdf[i]) / 3);
      for (int i = 1; i < BIN_COUNT; i++) begin
        red_cdf[i] = sum_sat(red_cdf[i], red_cdf[i-1]);
        green_cdf[i] = sum_sat(green_cdf[i], green_cdf[i-1]);
        blue_cdf[i] = sum_sat(blue_cdf[i], blue_cdf[i-1]);
        avg_cdf[i] = sum_sat(avg_cdf[i], avg_cdf[i-1]);
      end
    endfunction

    function logic [PIX_W-1:0] equalize(int unsigned cdf);
      longint unsigned q;
      if (pixel_total == 0) return '0;
      q = (longint'(255) * cdf) / pixel_total;
      return (q > 255) ? PIX_MAX : PIX_W'(q);
    endfunction

    function void note_input(logic func, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] b);
      rgb_t px;
      if (func == FUNC_COUNT) begin
        if (mapping) begin
          clear_bins();
          mapping = 0;
        end
        red_cdf[r] = bump(red_cdf[r]);
        green_cdf[g] = bump(green_cdf[g]);
        blue_cdf[b] = bump(blue_cdf[b]);
        pixel_total = bump(pixel_total);
      end else begin
        if (!mapping) begin
          accumulate();
          mapping = 1;
        end
        if (avg_mode) begin
          px.red = equalize(avg_cdf[r]);
          px.green = equalize(avg_cdf[g]);
          px.blue = equalize(avg_cdf[b]);
        end else begin
          px.red = equalize(red_cdf[r]);
          px.green = equalize(green_cdf[g]);
          px.blue = equalize(blue_cdf[b]);
        end
        mapped_pixels.push_back(px);
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                               logic [PIX_W-1:0] b);
      rgb_t px;
      if (mapped_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d", r, g, b);
        return;
      end
      px = mapped_pixels.pop_front();
      if (r !== px.red || g !== px.green || b !== px.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                   px.red, px.green, px.blue, r, g, b);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_func = 0;
  logic [PIX_W-1:0] in_red_in = 0, in_green_in = 0, in_blue_in = 0;
  logic out_valid;
  logic [PIX_W-1:0] out_red_out, out_green_out, out_blue_out;
  logic cfg_we = 0;
  logic cfg_average_mode = 0;

  equalizer_scoreboard sb = new();
  int items_sent = 0;
  bit no_gaps = 0;
  int stall_cycles = 0;
  bit finishing = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  histogram_equalizer_rgb_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_red_in(in_red_in), .in_green_in(in_green_in),
    .in_blue_in(in_blue_in), .out_valid(out_valid), .out_red_out(out_red_out),
    .out_green_out(out_green_out), .out_blue_out(out_blue_out),
    .cfg_we(cfg_we), .cfg_average_mode(cfg_average_mode)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_red_out, out_green_out, out_blue_out);
  end

  // Count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n || finishing) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_pixel(logic func, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] b);
    int gap;
    @(negedge clk);
    start <= 1;
    in_func <= func;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(posedge clk); while (busy);
    sb.note_input(func, r, g, b);
    items_sent++;
    if (!no_gaps && $urandom_range(0, 99) < 29) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (sb.mapped_pixels.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic write_mode(bit mode);
    drain();
    @(negedge clk);
    cfg_we <= 1;
    cfg_average_mode <= mode;
    @(negedge clk);
    cfg_we <= 0;
    sb.avg_mode = mode;
  endtask

  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return PIX_W'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? PIX_MAX : '0;
      2: return PIX_W'($urandom_range(100, 110));
      default: return PIX_W'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    int n;
    sb.clear_bins();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // map with zero count
    write_mode(0);
    send_pixel(FUNC_MAP, 0, 0, 0);
    send_pixel(FUNC_MAP, 255, 255, 255);
    send_pixel(FUNC_COUNT, 0, 0, 0);
    send_pixel(FUNC_COUNT, 255, 255, 255);
    send_pixel(FUNC_COUNT, 8'h55, 8'hAA, 8'h0F);
    send_pixel(FUNC_COUNT, 8'hAA, 8'h55, 8'hF0);
    send_pixel(FUNC_COUNT, 8'h80, 8'h01, 8'h7F);
    send_pixel(FUNC_MAP, 0, 0, 0);
    send_pixel(FUNC_MAP, 255, 255, 255);
    send_pixel(FUNC_MAP, 8'h55, 8'hAA, 8'h0F);
    send_pixel(FUNC_MAP, 8'h80, 8'h7F, 8'h01);
    // switch mode inside a map pass
    write_mode(1);
    send_pixel(FUNC_MAP, 0, 255, 8'h80);
    send_pixel(FUNC_MAP, 8'hAA, 8'h55, 8'hF0);
    send_pixel(FUNC_COUNT, 8'h10, 8'h20, 8'h30);
    send_pixel(FUNC_COUNT, 8'h10, 8'h20, 8'h30);
    send_pixel(FUNC_MAP, 8'h10, 8'h20, 8'h30);
    send_pixel(FUNC_MAP, 8'h0F, 8'h1F, 8'h2F);
    write_mode(0);
    send_pixel(FUNC_MAP, 8'h10, 8'h20, 8'hFF);

    while (items_sent < 1100) begin
      no_gaps = (items_sent > 400 && items_sent < 600);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(4, 20);
        repeat (n) send_pixel(1'($urandom_range(0, 1)), pick_level(), pick_level(),
                              pick_level());
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
        repeat (n) send_pixel(FUNC_COUNT, pick_level(), pick_level(), pick_level());
        n = $urandom_range(1, 30);
        repeat (n) send_pixel(FUNC_MAP, pick_level(), pick_level(), pick_level());
        if ($urandom_range(0, 3) == 0) begin
          write_mode(!sb.avg_mode);
          n = $urandom_range(1, 10);
          repeat (n) send_pixel(FUNC_MAP, pick_level(), pick_level(), pick_level());
        end
      end
    end

    @(negedge clk);
    start <= 0;
    while (sb.mapped_pixels.size() != 0) @(posedge clk);
    finishing = 1;
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/hequ_pkg.sv
rtl/hequ_front.sv
rtl/hequ_back.sv
rtl/histogram_equalizer_rgb_unit.sv
tb/testbench.sv
